FILE: src/tlph_pkg.sv
// ----------------------------------------------------------------------------
// Tagged linear probe hash map: shared package
// Operation codes, status codes and slot tag markers used by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tlph_pkg;

   localparam int TAG_W = 8;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOOKUP = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_DELETE = 2'd2;
   localparam op_type OP_SPARE  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   typedef logic [TAG_W-1:0] tag_type;
   localparam tag_type TAG_EMPTY = 8'h80;
   localparam tag_type TAG_DEAD  = 8'hFE;
   localparam tag_type TAG_MASK  = 8'h7F;

endpackage

`default_nettype wire

FILE: src/tlph_front.sv
// ----------------------------------------------------------------------------
// Tagged linear probe hash map: request front end
// Accepts request beats, classifies the command and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tlph_front #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_command,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [31:0]           req_key_hash,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       q_valid,
   input  wire logic                  q_pop,
   output tlph_pkg::op_type           q_op,
   output logic [KEY_BITS-1:0]        q_key,
   output logic [31:0]                q_hash,
   output logic [VALUE_BITS-1:0]      q_value
);
   import tlph_pkg::*;

   op_type                op_ff    [2];
   logic [KEY_BITS-1:0]   key_ff   [2];
   logic [31:0]           hash_ff  [2];
   logic [VALUE_BITS-1:0] value_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   op_type                op_class;

   always_comb begin
      case (req_command)
         OP_INSERT: op_class = OP_INSERT;
         OP_DELETE: op_class = OP_DELETE;
         default:   op_class = OP_LOOKUP;
      endcase
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_op    = op_ff[rd_ptr_ff];
   assign q_key   = key_ff[rd_ptr_ff];
   assign q_hash  = hash_ff[rd_ptr_ff];
   assign q_value = value_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]    <= op_class;
         key_ff[wr_ptr_ff]   <= req_key;
         hash_ff[wr_ptr_ff]  <= req_key_hash;
         value_ff[wr_ptr_ff] <= req_value;
      end
   end

endmodule

`default_nettype wire

FILE: src/tlph_engine.sv
// ----------------------------------------------------------------------------
// Tagged linear probe hash map: table engine
// Holds the slot stores and the shadow bank, walks probes one slot at a
// time, rebuilds the table on growth or compaction and issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module tlph_engine #(
   parameter int TABLE_DEPTH  = 64,
   parameter int BASE_SLOTS   = 8,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32,
   parameter int SW           = $clog2(TABLE_DEPTH),
   parameter int CW           = $clog2(TABLE_DEPTH) + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_pop,
   input  wire tlph_pkg::op_type      q_op,
   input  wire logic [KEY_BITS-1:0]   q_key,
   input  wire logic [31:0]           q_hash,
   input  wire logic [VALUE_BITS-1:0] q_value,
   output logic                       rsp_valid,
   output tlph_pkg::status_type       rsp_status,
   output logic                       rsp_found,
   output logic [VALUE_BITS-1:0]      rsp_value_out,
   output logic [SW-1:0]              rsp_slot_index,
   output logic [CW-1:0]              rsp_entry_count,
   output logic [CW-1:0]              rsp_capacity_now
);
   import tlph_pkg::*;

   localparam int SHW = TAG_W + KEY_BITS + 32 + VALUE_BITS;
   localparam int GW  = CW + 4;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CPY_RD  = 4'd1;
   localparam logic [3:0] S_CPY_WR  = 4'd2;
   localparam logic [3:0] S_RIN_RD  = 4'd3;
   localparam logic [3:0] S_RIN_CHK = 4'd4;
   localparam logic [3:0] S_FND_RD  = 4'd5;
   localparam logic [3:0] S_FND_CHK = 4'd6;
   localparam logic [3:0] S_PRB_BEG = 4'd7;
   localparam logic [3:0] S_PRB_RD  = 4'd8;
   localparam logic [3:0] S_PRB_CHK = 4'd9;

   tag_type               tag_mem  [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   key_mem  [TABLE_DEPTH];
   logic [31:0]           hash_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem  [TABLE_DEPTH];
   logic [SHW-1:0]        sh_mem   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] used_ff, used_in;

   tag_type               tag_q;
   logic [KEY_BITS-1:0]   key_q;
   logic [31:0]           hash_q;
   logic [VALUE_BITS-1:0] val_q;
   logic                  used_q;
   logic [SHW-1:0]        sh_q;

   logic [3:0]            state_ff, state_in;
   logic [SW-1:0]         idx_ff, idx_in;
   logic [SW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         ncap_ff, ncap_in;
   logic [CW-1:0]         live_ff, live_in;
   logic [CW-1:0]         tomb_ff, tomb_in;
   logic [CW-1:0]         cap_ff, cap_in;
   op_type                op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [31:0]           hash_ff, hash_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;

   logic                  rv_ff, rv_in;
   status_type            rst_ff, rst_in;
   logic                  rfd_ff, rfd_in;
   logic [VALUE_BITS-1:0] rvo_ff, rvo_in;
   logic [SW-1:0]         rsl_ff, rsl_in;

   logic [SW-1:0]         mem_addr;
   logic                  we_tag, we_kh, we_val, sh_we;
   tag_type               wr_tag;
   logic [KEY_BITS-1:0]   wr_key;
   logic [31:0]           wr_hash;
   logic [VALUE_BITS-1:0] wr_val;

   tag_type               sh_tag;
   logic [KEY_BITS-1:0]   sh_key;
   logic [31:0]           sh_hash;
   logic [VALUE_BITS-1:0] sh_val;

   logic [SW-1:0]         mask, nmask;
   logic                  grow_due, pack_due, sh_live, last_idx, hit;
   logic [CW-1:0]         grown_cap;
   tag_type               probe_tag;

   assign {sh_tag, sh_key, sh_hash, sh_val} = sh_q;
   assign mask      = cap_ff[SW-1:0] - 1'b1;
   assign nmask     = ncap_ff[SW-1:0] - 1'b1;
   assign grow_due  = ((GW'(live_ff) + GW'(tomb_ff)) << 3) >
                      ((GW'(cap_ff) << 3) - GW'(cap_ff));
   assign pack_due  = (GW'(live_ff) << 1) < GW'(cap_ff) && tomb_ff > (cap_ff >> 2);
   assign grown_cap = (cap_ff == CW'(TABLE_DEPTH)) ? cap_ff : (cap_ff << 1);
   assign sh_live   = sh_tag != TAG_EMPTY && sh_tag != TAG_DEAD;
   assign last_idx  = CW'(idx_ff) == cap_ff - 1'b1;
   assign probe_tag = hash_ff[TAG_W-1:0] & TAG_MASK;
   assign hit       = used_q && tag_q == probe_tag && key_q == key_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      ncap_in  = ncap_ff;
      live_in  = live_ff;
      tomb_in  = tomb_ff;
      cap_in   = cap_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      hash_in  = hash_ff;
      val_in   = val_ff;
      rv_in    = 1'b0;
      rst_in   = rst_ff;
      rfd_in   = rfd_ff;
      rvo_in   = rvo_ff;
      rsl_in   = rsl_ff;
      used_in  = used_ff;
      q_pop    = 1'b0;
      mem_addr = pos_ff;
      we_tag   = 1'b0;
      we_kh    = 1'b0;
      we_val   = 1'b0;
      sh_we    = 1'b0;
      wr_tag   = probe_tag;
      wr_key   = key_ff;
      wr_hash  = hash_ff;
      wr_val   = val_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               op_in   = q_op;
               key_in  = q_key;
               hash_in = q_hash;
               val_in  = q_value;
               idx_in  = '0;
               if (q_op == OP_INSERT && grow_due) begin
                  ncap_in  = grown_cap;
                  state_in = S_CPY_RD;
               end else if (q_op == OP_DELETE && pack_due) begin
                  ncap_in  = cap_ff;
                  state_in = S_CPY_RD;
               end else begin
                  state_in = S_PRB_BEG;
               end
            end
         end
         S_CPY_RD: begin
            mem_addr = idx_ff;
            state_in = S_CPY_WR;
         end
         S_CPY_WR: begin
            sh_we = 1'b1;
            if (last_idx) begin
               used_in  = '0;
               idx_in   = '0;
               state_in = S_RIN_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CPY_RD;
            end
         end
         S_RIN_RD: begin
            state_in = S_RIN_CHK;
         end
         S_RIN_CHK: begin
            if (sh_live) begin
               pos_in   = sh_hash[SW-1:0] & nmask;
               state_in = S_FND_RD;
            end else if (last_idx) begin
               cap_in   = ncap_ff;
               tomb_in  = '0;
               state_in = S_PRB_BEG;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RIN_RD;
            end
         end
         S_FND_RD: begin
            state_in = S_FND_CHK;
         end
         S_FND_CHK: begin
            if (!used_q) begin
               we_tag          = 1'b1;
               we_kh           = 1'b1;
               we_val          = 1'b1;
               wr_tag          = sh_tag;
               wr_key          = sh_key;
               wr_hash         = sh_hash;
               wr_val          = sh_val;
               used_in[pos_ff] = 1'b1;
               if (last_idx) begin
                  cap_in   = ncap_ff;
                  tomb_in  = '0;
                  state_in = S_PRB_BEG;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RIN_RD;
               end
            end else begin
               pos_in   = (pos_ff + 1'b1) & nmask;
               state_in = S_FND_RD;
            end
         end
         S_PRB_BEG: begin
            pos_in   = hash_ff[SW-1:0] & mask;
            cnt_in   = '0;
            state_in = S_PRB_RD;
         end
         S_PRB_RD: begin
            state_in = S_PRB_CHK;
         end
         S_PRB_CHK: begin
            if (hit || !used_q || cnt_ff == cap_ff - 1'b1) begin
               rv_in    = 1'b1;
               rst_in   = ST_MISS;
               rfd_in   = 1'b0;
               rvo_in   = '0;
               rsl_in   = pos_ff;
               state_in = S_IDLE;
               if (hit) begin
                  rst_in = ST_OK;
                  rfd_in = 1'b1;
                  case (op_ff)
                     OP_INSERT: we_val = 1'b1;
                     OP_DELETE: begin
                        we_tag  = 1'b1;
                        wr_tag  = TAG_DEAD;
                        live_in = live_ff - 1'b1;
                        tomb_in = tomb_ff + 1'b1;
                     end
                     default: rvo_in = val_q;
                  endcase
               end else if (!used_q) begin
                  if (op_ff == OP_INSERT) begin
                     we_tag          = 1'b1;
                     we_kh           = 1'b1;
                     we_val          = 1'b1;
                     used_in[pos_ff] = 1'b1;
                     live_in         = live_ff + 1'b1;
                     rst_in          = ST_OK;
                  end
               end else begin
                  rsl_in = '0;
                  if (op_ff == OP_INSERT) begin
                     rst_in = ST_FULL;
                  end
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = (pos_ff + 1'b1) & mask;
               state_in = S_PRB_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         tomb_ff  <= '0;
         cap_ff   <= CW'(BASE_SLOTS);
         used_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         tomb_ff  <= tomb_in;
         cap_ff   <= cap_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      ncap_ff <= ncap_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      hash_ff <= hash_in;
      val_ff  <= val_in;
      rst_ff  <= rst_in;
      rfd_ff  <= rfd_in;
      rvo_ff  <= rvo_in;
      rsl_ff  <= rsl_in;
   end

   always_ff @(posedge clock) begin
      tag_q  <= tag_mem[mem_addr];
      key_q  <= key_mem[mem_addr];
      hash_q <= hash_mem[mem_addr];
      val_q  <= val_mem[mem_addr];
      used_q <= used_ff[mem_addr];
      sh_q   <= sh_mem[idx_ff];
      if (we_tag) begin
         tag_mem[mem_addr] <= wr_tag;
      end
      if (we_kh) begin
         key_mem[mem_addr]  <= wr_key;
         hash_mem[mem_addr] <= wr_hash;
      end
      if (we_val) begin
         val_mem[mem_addr] <= wr_val;
      end
      if (sh_we) begin
         sh_mem[idx_ff] <= {used_q ? tag_q : TAG_EMPTY, key_q, hash_q, val_q};
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_found        = rfd_ff;
   assign rsp_value_out    = rvo_ff;
   assign rsp_slot_index   = rsl_ff;
   assign rsp_entry_count  = live_ff;
   assign rsp_capacity_now = cap_ff;

endmodule

`default_nettype wire

FILE: src/tagged_linear_probe_hash_map_unit.sv
// ----------------------------------------------------------------------------
// Tagged linear probe hash map unit
// Lookup, insert and delete on a linearly probed table with 8-bit slot
// tags, growing by doubling and compacting through a shadow bank.
//
//   channel   handshake          payload
//   request   start / busy       req_command, req_key, req_key_hash, req_value
//   result    rsp_valid strobe   rsp_status, rsp_found, rsp_value_out,
//                                rsp_slot_index, rsp_entry_count,
//                                rsp_capacity_now
//
// A request probes one slot at a time through the registered read of the
// slot stores. A rebuild copies every old slot into the shadow bank, then
// reinserts each live entry from it, probing the new table slot by slot.
// A two-entry queue takes request beats while the engine works; busy is
// high when it is full. Results cannot be stalled. Reset clears used flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_linear_probe_hash_map_unit #(
   parameter int TABLE_DEPTH  = 64,
   parameter int BASE_SLOTS   = 8,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_command,
   input  wire logic [KEY_BITS-1:0]             req_key,
   input  wire logic [31:0]                     req_key_hash,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   output logic                                 rsp_valid,
   output tlph_pkg::status_type                 rsp_status,
   output logic                                 rsp_found,
   output logic [VALUE_BITS-1:0]                rsp_value_out,
   output logic [$clog2(TABLE_DEPTH)-1:0]       rsp_slot_index,
   output logic [$clog2(TABLE_DEPTH):0]         rsp_entry_count,
   output logic [$clog2(TABLE_DEPTH):0]         rsp_capacity_now
);
   import tlph_pkg::*;

   logic                  q_valid;
   logic                  q_pop;
   op_type                q_op;
   logic [KEY_BITS-1:0]   q_key;
   logic [31:0]           q_hash;
   logic [VALUE_BITS-1:0] q_value;

   tlph_front #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_key      (req_key),
      .req_key_hash (req_key_hash),
      .req_value    (req_value),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_op         (q_op),
      .q_key        (q_key),
      .q_hash       (q_hash),
      .q_value      (q_value)
   );

   tlph_engine #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .BASE_SLOTS   (BASE_SLOTS),
      .KEY_BITS     (KEY_BITS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_op             (q_op),
      .q_key            (q_key),
      .q_hash           (q_hash),
      .q_value          (q_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_value_out    (rsp_value_out),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_capacity_now (rsp_capacity_now)
   );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the tagged linear probe hash map unit
// Drives lookup, insert, delete and spare-code beats, predicts every result with a
// behavioural copy of the table, and checks each result strobe in order.
// ----------------------------------------------------------------------------

module tb_top;
   import tlph_pkg::*;

   localparam int DEPTH   = 64;
   localparam int MIN_CAP = 8;
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [31:0] req_key = '0;
   logic [31:0] req_key_hash = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   status_type  rsp_status;
   logic        rsp_found;
   logic [31:0] rsp_value_out;
   logic [5:0]  rsp_slot_index;
   logic [6:0]  rsp_entry_count;
   logic [6:0]  rsp_capacity_now;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [31:0] value_out;
      logic [5:0]  slot_index;
      logic [6:0]  entry_count;
      logic [6:0]  capacity_now;
   } map_result_type;

   map_result_type expected_results[$];
   tag_type     map_tag[DEPTH];
   logic [31:0] map_key[DEPTH];
   logic [31:0] map_hash[DEPTH];
   logic [31:0] map_value[DEPTH];
   int          map_live;
   int          map_dead;
   int          map_cap;
   int          error_count = 0;
   longint      cycle_count = 0;
   int          idle_pct = 0;
   logic [31:0] key_pool[$];

   tagged_linear_probe_hash_map_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_key(req_key), .req_key_hash(req_key_hash),
      .req_value(req_value), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_found(rsp_found), .rsp_value_out(rsp_value_out),
      .rsp_slot_index(rsp_slot_index), .rsp_entry_count(rsp_entry_count),
      .rsp_capacity_now(rsp_capacity_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit map_probe(logic [31:0] key, logic [31:0] hash,
                                    output int slot, output bit stopped);
      int i;
      tag_type t;
      i = hash & (map_cap - 1);
      t = hash[7:0] & TAG_MASK;
      for (int n = 0; n < map_cap; n++) begin
         if (map_tag[i] == t && map_key[i] == key) begin
            slot = i; stopped = 1; return 1;
         end
         if (map_tag[i] == TAG_EMPTY) begin
            slot = i; stopped = 1; return 0;
         end
         i = (i + 1) & (map_cap - 1);
      end
      slot = 0; stopped = 0;
      return 0;
   endfunction

   function automatic void map_rebuild(int new_cap);
      tag_type     st[DEPTH];
      logic [31:0] sk[DEPTH];
      logic [31:0] sh[DEPTH];
      logic [31:0] sv[DEPTH];
      int          j;
      for (int i = 0; i < DEPTH; i++) begin
         st[i] = map_tag[i]; sk[i] = map_key[i]; sh[i] = map_hash[i];
         sv[i] = map_value[i]; map_tag[i] = TAG_EMPTY;
      end
      for (int i = 0; i < map_cap; i++) begin
         if (st[i] == TAG_EMPTY || st[i] == TAG_DEAD) continue;
         j = sh[i] & (new_cap - 1);
         for (int n = 0; n < new_cap && map_tag[j] != TAG_EMPTY; n++)
            j = (j + 1) & (new_cap - 1);
         map_tag[j] = st[i]; map_key[j] = sk[i]; map_hash[j] = sh[i];
         map_value[j] = sv[i];
      end
      map_cap  = new_cap;
      map_dead = 0;
   endfunction

   function automatic map_result_type map_predict(op_type cmd, logic [31:0] key,
                                                  logic [31:0] hash, logic [31:0] val);
      map_result_type r;
      int          slot;
      bit          stopped;
      bit          hit;
      r = '0;
      r.status = ST_MISS;
      if (cmd == OP_INSERT) begin
         if (8 * (map_live + map_dead) > 7 * map_cap)
            map_rebuild((map_cap * 2 > DEPTH) ? DEPTH : map_cap * 2);
         hit = map_probe(key, hash, slot, stopped);
         if (hit) begin
            map_value[slot] = val; r.status = ST_OK; r.found = 1;
         end else if (stopped) begin
            map_tag[slot] = hash[7:0] & TAG_MASK; map_key[slot] = key;
            map_hash[slot] = hash; map_value[slot] = val;
            map_live++; r.status = ST_OK;
         end else begin
            r.status = ST_FULL;
         end
      end else if (cmd == OP_DELETE) begin
         if (2 * map_live < map_cap && map_dead > map_cap / 4)
            map_rebuild(map_cap);
         hit = map_probe(key, hash, slot, stopped);
         if (hit) begin
            map_tag[slot] = TAG_DEAD; map_live--; map_dead++;
            r.status = ST_OK; r.found = 1;
         end
      end else begin
         hit = map_probe(key, hash, slot, stopped);
         if (hit) begin
            r.value_out = map_value[slot]; r.status = ST_OK; r.found = 1;
         end
      end
      r.slot_index   = slot[5:0];
      r.entry_count  = map_live[6:0];
      r.capacity_now = map_cap[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      map_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result beat with no request outstanding");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_found !== e.found) begin
               $error("found: expected %0d, actual %0d", e.found, rsp_found);
               error_count++;
            end
            if (rsp_value_out !== e.value_out) begin
               $error("value_out: expected %h, actual %h", e.value_out, rsp_value_out);
               error_count++;
            end
            if (rsp_slot_index !== e.slot_index) begin
               $error("slot_index: expected %0d, actual %0d", e.slot_index,
                      rsp_slot_index);
               error_count++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", e.entry_count,
                      rsp_entry_count);
               error_count++;
            end
            if (rsp_capacity_now !== e.capacity_now) begin
               $error("capacity_now: expected %0d, actual %0d", e.capacity_now,
                      rsp_capacity_now);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(op_type cmd, logic [31:0] key, logic [31:0] hash,
                               logic [31:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_key      <= key;
      req_key_hash <= hash;
      req_value    <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(map_predict(cmd, key, hash, val));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(OP_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_INSERT, 32'h1, 32'h0, 32'hA5A5_5A5A);
      send_request(OP_INSERT, 32'h0, 32'h0, 32'h1234_5678);
      send_request(OP_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(OP_SPARE, 32'h1, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h1, 32'h80, 32'h0);
      send_request(OP_DELETE, 32'h0, 32'h0, 32'h0);
      send_request(OP_LOOKUP, 32'h1, 32'h0, 32'h0);
      send_request(OP_DELETE, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 10; i++)
         send_request(OP_INSERT, 32'h100 + i, 32'h0000_0300 + i, i);
      send_request(OP_LOOKUP, 32'h105, 32'h305, 32'h0);
      drain_results();
   endtask

   task automatic random_phase(int count, int pct);
      op_type      cmd;
      logic [31:0] key, hash;
      int          r;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         cmd = (r < 50) ? OP_INSERT : (r < 75) ? OP_DELETE :
               (r < 97) ? OP_LOOKUP : OP_SPARE;
         if (key_pool.size() != 0 && $urandom_range(99) < 70)
            key = key_pool[$urandom_range(key_pool.size() - 1)];
         else begin
            key = $urandom;
            key_pool.push_back(key);
         end
         hash = key ^ (key >> 7);
         if ($urandom_range(99) < 10) hash = $urandom;
         send_request(cmd, key, hash, $urandom);
      end
      drain_results();
   endtask

   task automatic test_fill_and_saturate();
      idle_pct = 0;
      for (int i = 0; i < 75; i++)
         send_request(OP_INSERT, $urandom, $urandom, $urandom);
      for (int i = 0; i < 70; i++)
         send_request(OP_DELETE, $urandom, $urandom, 32'h0);
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         map_tag[i] = TAG_EMPTY; map_key[i] = '0; map_hash[i] = '0; map_value[i] = '0;
      end
      map_live = 0; map_dead = 0; map_cap = MIN_CAP;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      random_phase(150, 0);
      random_phase(150, 88);
      random_phase(150, 38);
      random_phase(150, 0);
      test_fill_and_saturate();
      repeat (3000) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
